// File: src/vpn_peer_forwarding_decision_defines.svh
// Assertion macros used by the peer forwarding back end.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef VPN_PEER_FORWARDING_DECISION_DEFINES_SVH
`define VPN_PEER_FORWARDING_DECISION_DEFINES_SVH

`ifndef SYNTHESIS

`define VPNFD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define VPNFD_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define VPNFD_ASSERT(lbl, prop, msg)

`define VPNFD_NEVER(lbl, expr, msg)

`endif

`endif

// File: src/vpnfd_pkg.sv
// Types, codes and sizes for the peer forwarding decision block.
// No dependencies; imported by every module of the block.
`default_nettype none

package vpnfd_pkg;

    // table is indexed by the host byte of an address or by the peer id
    localparam int TABLE_DEPTH = 256;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int PEER_SLOTS  = 256;
    localparam int FULL_LIMIT  = PEER_SLOTS - 1;
    localparam int COUNT_W     = $clog2(PEER_SLOTS);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_LINK   = 2'd1;
    localparam logic [1:0] OP_TUNNEL = 2'd2;

    localparam logic [1:0] CFG_SERVER_IP   = 2'd0;
    localparam logic [1:0] CFG_SERVER_MASK = 2'd1;
    localparam logic [1:0] CFG_EXPIRE      = 2'd2;

    localparam logic [31:0] SERVER_IP_RESET   = 32'h0000_0000;
    localparam logic [31:0] SERVER_MASK_RESET = 32'hffff_ff00;
    localparam logic [15:0] EXPIRE_RESET      = 16'd600;

    typedef enum logic [1:0] {
        ACT_DROP   = 2'd0,
        ACT_PEER   = 2'd1,
        ACT_TUNNEL = 2'd2,
        ACT_ACCEPT = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        RSN_NONE         = 4'd0,
        RSN_NO_PEER      = 4'd1,
        RSN_BAD_PACKET   = 4'd2,
        RSN_WRONG_SRC    = 4'd3,
        RSN_NO_DEST      = 4'd4,
        RSN_SRC_LAN_OFF  = 4'd5,
        RSN_DST_LAN_OFF  = 4'd6,
        RSN_EXPIRED      = 4'd7,
        RSN_SRC_INET_OFF = 4'd8,
        RSN_DST_INET_OFF = 4'd9,
        RSN_BAD_IP       = 4'd10,
        RSN_EXISTS       = 4'd11,
        RSN_FULL         = 4'd12
    } reason_t;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_RD_SRC,
        BS_RD_DST,
        BS_DECIDE
    } back_state_t;

    // classified word handed from front to back
    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] now;
        logic [7:0]  pid;
        logic [31:0] sip;
        logic [31:0] dip;
        logic        ok;
        logic [47:0] raddr;
        logic [31:0] eip;
        logic        einet;
        logic        elan;
        logic        eip_peer;
        logic        dip_peer;
        logic        dip_net;
        logic        dip_server;
        logic        sip_server;
    } item_t;

    typedef struct packed {
        action_t     action;
        reason_t     reason;
        logic        block_source;
        logic [7:0]  target_peer;
        logic [47:0] target_addr;
    } result_t;

    typedef struct packed {
        logic [31:0] ip;
        logic        inet;
        logic        lan;
        logic [31:0] last_seen;
        logic [47:0] endpoint;
    } slot_row_t;

endpackage

`default_nettype wire

// File: src/vpnfd_front.sv
// Front end: accepts input words, classifies addresses against the server net,
// and queues the classified words for the back end. Uses vpnfd_pkg.
`default_nettype none

module vpnfd_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       operation,
    input  logic [31:0]      now_seconds,
    input  logic [7:0]       peer_id,
    input  logic [31:0]      src_ip,
    input  logic [31:0]      dst_ip,
    input  logic             packet_ok,
    input  logic [47:0]      remote_addr,
    input  logic [31:0]      entry_ip,
    input  logic             entry_inet,
    input  logic             entry_lan,
    input  logic [31:0]      server_ip,
    input  logic [31:0]      server_mask,
    output logic             q_valid,
    output vpnfd_pkg::item_t q_item,
    input  logic             q_pop
);
    import vpnfd_pkg::*;

    item_t              cls;
    logic [31:0]        net;
    item_t              fifo_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;
    logic               push;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] r;
        if (p == QPTR_W'(QUEUE_DEPTH - 1))
            r = '0;
        else
            r = p + QPTR_W'(1);
        return r;
    endfunction

    // private peer address: inside the net, not the server and not the net itself
    function automatic logic is_peer(input logic [31:0] a, input logic [31:0] sip,
                                     input logic [31:0] mask, input logic [31:0] n);
        return (a != sip) && (a != n) && ((a & mask) == n);
    endfunction

    assign net = server_ip & server_mask;

    always_comb
    begin
        cls.op         = operation;
        cls.now        = now_seconds;
        cls.pid        = peer_id;
        cls.sip        = src_ip;
        cls.dip        = dst_ip;
        cls.ok         = packet_ok;
        cls.raddr      = remote_addr;
        cls.eip        = entry_ip;
        cls.einet      = entry_inet;
        cls.elan       = entry_lan;
        cls.eip_peer   = is_peer(entry_ip, server_ip, server_mask, net);
        cls.dip_peer   = is_peer(dst_ip, server_ip, server_mask, net);
        cls.dip_net    = (dst_ip == net);
        cls.dip_server = (dst_ip == server_ip);
        cls.sip_server = (src_ip == server_ip);
    end

    assign in_ready = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != '0);
    assign q_item   = fifo_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = q_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !q_pop)
            cnt_next = cnt_reg + QCNT_W'(1);
        else if (!push && q_pop)
            cnt_next = cnt_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_mem[wr_ptr_reg] <= cls;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// File: src/vpnfd_back.sv
// Back end: peer table, sequencer for the two table reads and write-back,
// and the output register. Uses vpnfd_pkg and the assertion macro header.
`default_nettype none
`include "vpn_peer_forwarding_decision_defines.svh"

module vpnfd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  vpnfd_pkg::item_t   q_item,
    output logic               q_pop,
    input  logic [15:0]        expire_seconds,
    output logic               out_valid,
    input  logic               out_ready,
    output vpnfd_pkg::result_t out_res
);
    import vpnfd_pkg::*;

    back_state_t         state_reg, state_next;
    item_t               cur_reg;
    slot_row_t           slot_mem [TABLE_DEPTH];
    slot_row_t           rdata_reg;
    slot_row_t           src_row_reg;
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [COUNT_W-1:0]  peer_count_reg;
    logic                out_valid_reg, out_valid_next;
    result_t             out_res_reg;

    logic                rd_en;
    logic [SLOT_W-1:0]   rd_addr;
    logic                dec_fire;
    logic                out_free;

    result_t             res;
    logic                mem_we;
    logic [SLOT_W-1:0]   mem_waddr;
    slot_row_t           mem_wdata;
    logic                valid_set;
    logic                count_inc;
    logic                mem_we_fire;
    logic                valid_set_fire;

    logic [SLOT_W-1:0]   d_slot;
    logic [SLOT_W-1:0]   e_slot;
    slot_row_t           upd_row;
    slot_row_t           new_row;
    slot_row_t           dst_row;
    logic [32:0]         deadline;
    logic                expired;
    logic                dst_missing;

    assign out_free = !out_valid_reg || out_ready;
    assign d_slot   = cur_reg.dip[SLOT_W-1:0];
    assign e_slot   = cur_reg.eip[SLOT_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BS_IDLE:   if (q_valid) state_next = BS_RD_SRC;
            BS_RD_SRC: state_next = BS_RD_DST;
            BS_RD_DST: state_next = BS_DECIDE;
            BS_DECIDE: if (out_free) state_next = BS_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        q_pop    = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = d_slot;
        dec_fire = 1'b0;
        unique case (state_reg)
            BS_IDLE:   q_pop = q_valid;
            BS_RD_SRC:
            begin
                rd_en   = 1'b1;
                rd_addr = (cur_reg.op == OP_LINK) ? cur_reg.pid[SLOT_W-1:0] : d_slot;
            end
            BS_RD_DST: rd_en = 1'b1;
            BS_DECIDE: dec_fire = out_free;
        endcase
    end

    // row after a link packet refreshes the sender
    always_comb
    begin
        upd_row           = src_row_reg;
        upd_row.last_seen = cur_reg.now;
        upd_row.endpoint  = cur_reg.raddr;
        new_row.ip        = cur_reg.eip;
        new_row.inet      = cur_reg.einet;
        new_row.lan       = cur_reg.elan;
        new_row.last_seen = '0;
        new_row.endpoint  = '0;
        // sender sending to itself sees its own fresh record
        if (cur_reg.op == OP_LINK && d_slot == cur_reg.pid[SLOT_W-1:0])
            dst_row = upd_row;
        else
            dst_row = rdata_reg;
        deadline    = {1'b0, dst_row.last_seen} + {17'b0, expire_seconds};
        expired     = {1'b0, cur_reg.now} > deadline;
        dst_missing = !valid_reg[d_slot] || (dst_row.ip != cur_reg.dip)
                      || (dst_row.last_seen == '0);
    end

    always_comb
    begin
        res.action       = ACT_DROP;
        res.reason       = RSN_NONE;
        res.block_source = 1'b0;
        res.target_peer  = '0;
        res.target_addr  = '0;
        mem_we           = 1'b0;
        mem_waddr        = cur_reg.pid[SLOT_W-1:0];
        mem_wdata        = upd_row;
        valid_set        = 1'b0;
        count_inc        = 1'b0;
        unique case (cur_reg.op)
            OP_WRITE:
            begin
                priority if (!cur_reg.eip_peer)
                    res.reason = RSN_BAD_IP;
                else if (peer_count_reg >= COUNT_W'(FULL_LIMIT))
                    res.reason = RSN_FULL;
                else if (valid_reg[e_slot])
                    res.reason = RSN_EXISTS;
                else
                begin
                    res.action = ACT_ACCEPT;
                    mem_we     = 1'b1;
                    mem_waddr  = e_slot;
                    mem_wdata  = new_row;
                    valid_set  = 1'b1;
                    count_inc  = 1'b1;
                end
            end
            OP_LINK:
            begin
                priority if (!valid_reg[cur_reg.pid[SLOT_W-1:0]])
                begin
                    res.reason       = RSN_NO_PEER;
                    res.block_source = 1'b1;
                end
                else if (!cur_reg.ok)
                begin
                    res.reason       = RSN_BAD_PACKET;
                    res.block_source = 1'b1;
                end
                else if (cur_reg.sip != src_row_reg.ip)
                begin
                    res.reason       = RSN_WRONG_SRC;
                    res.block_source = 1'b1;
                end
                else
                begin
                    mem_we = 1'b1;
                    if (cur_reg.dip_peer)
                    begin
                        priority if (dst_missing)
                            res.reason = RSN_NO_DEST;
                        else if (!src_row_reg.lan)
                            res.reason = RSN_SRC_LAN_OFF;
                        else if (!dst_row.lan)
                            res.reason = RSN_DST_LAN_OFF;
                        else if (expired)
                            res.reason = RSN_EXPIRED;
                        else
                        begin
                            res.action      = ACT_PEER;
                            res.target_peer = 8'(d_slot);
                            res.target_addr = dst_row.endpoint;
                        end
                    end
                    else
                    begin
                        priority if (cur_reg.dip_net)
                            res.reason = RSN_NO_DEST;
                        else if (!src_row_reg.inet && !cur_reg.dip_server)
                            res.reason = RSN_SRC_INET_OFF;
                        else
                            res.action = ACT_TUNNEL;
                    end
                end
            end
            OP_TUNNEL:
            begin
                priority if (!cur_reg.ok)
                    res.reason = RSN_BAD_PACKET;
                else if (dst_missing)
                    res.reason = RSN_NO_DEST;
                else if (!dst_row.inet && !cur_reg.sip_server)
                    res.reason = RSN_DST_INET_OFF;
                else if (expired)
                    res.reason = RSN_EXPIRED;
                else
                begin
                    res.action      = ACT_PEER;
                    res.target_peer = 8'(d_slot);
                    res.target_addr = dst_row.endpoint;
                end
            end
            default: ;
        endcase
    end

    assign mem_we_fire    = dec_fire && mem_we;
    assign valid_set_fire = dec_fire && valid_set;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (dec_fire)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // table memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we_fire)
            slot_mem[mem_waddr] <= mem_wdata;
        if (rd_en)
            rdata_reg <= slot_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cur_reg <= q_item;
        if (state_reg == BS_RD_DST)
            src_row_reg <= rdata_reg;
        if (dec_fire)
            out_res_reg <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BS_IDLE;
            valid_reg      <= '0;
            peer_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (valid_set_fire)
                valid_reg[mem_waddr] <= 1'b1;
            if (dec_fire && count_inc)
                peer_count_reg <= peer_count_reg + COUNT_W'(1);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    `VPNFD_ASSERT(a_pop_in_idle, q_pop |-> (state_reg == BS_IDLE), "queue pop outside idle")
    `VPNFD_ASSERT(a_count_limit, peer_count_reg <= COUNT_W'(FULL_LIMIT), "peer count over limit")
    `VPNFD_ASSERT(a_result_from_decide, $rose(out_valid_reg) |-> $past(state_reg == BS_DECIDE), "result outside decide")
    `VPNFD_NEVER(a_write_outside_decide, mem_we_fire && (state_reg != BS_DECIDE), "table write outside decide")
    `VPNFD_ASSERT(a_no_double_add, valid_set_fire |-> !valid_reg[mem_waddr], "slot added twice")

endmodule

`default_nettype wire

// File: src/vpn_peer_forwarding_decision.sv
// VPN peer forwarding decision, top level.
// Channels: input words (in_valid/in_ready) carry one operation each: write a
// peer entry, a packet from the link, or a packet from the tunnel. Each word
// yields exactly one result word (out_valid/out_ready): action, reason,
// block_source, target_peer and target_addr.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready;
// index 0 server_ip, 1 server_mask, 2 expire_seconds (low 16 bits), other
// indexes are ignored. Write it only while the block is idle.
// An accepted word passes through the queue and then the back-end
// sequencer, which handles one word at a time and pops the next only after the
// last one is decided: pop, read source row, read destination row, decide and
// write back through the table's single read port.
// A two-word queue sits between front and back; while out_ready is low the
// result is held, the back end waits, the queue fills and in_ready drops.
// Reset clears all slot valid bits and the peer count at once (no sweep) and
// restores the configuration defaults.
// Uses vpnfd_pkg, vpnfd_front and vpnfd_back.
`default_nettype none

module vpn_peer_forwarding_decision (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [31:0] now_seconds,
    input  logic [7:0]  peer_id,
    input  logic [31:0] src_ip,
    input  logic [31:0] dst_ip,
    input  logic        packet_ok,
    input  logic [47:0] remote_addr,
    input  logic [31:0] entry_ip,
    input  logic        entry_inet,
    input  logic        entry_lan,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  action,
    output logic [3:0]  reason,
    output logic        block_source,
    output logic [7:0]  target_peer,
    output logic [47:0] target_addr,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import vpnfd_pkg::*;

    logic [31:0] server_ip_reg;
    logic [31:0] server_mask_reg;
    logic [15:0] expire_reg;
    logic        q_valid;
    logic        q_pop;
    item_t       q_item;
    result_t     res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            server_ip_reg   <= SERVER_IP_RESET;
            server_mask_reg <= SERVER_MASK_RESET;
            expire_reg      <= EXPIRE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SERVER_IP:   server_ip_reg   <= cfg_data;
                CFG_SERVER_MASK: server_mask_reg <= cfg_data;
                CFG_EXPIRE:      expire_reg      <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    vpnfd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .now_seconds (now_seconds),
        .peer_id     (peer_id),
        .src_ip      (src_ip),
        .dst_ip      (dst_ip),
        .packet_ok   (packet_ok),
        .remote_addr (remote_addr),
        .entry_ip    (entry_ip),
        .entry_inet  (entry_inet),
        .entry_lan   (entry_lan),
        .server_ip   (server_ip_reg),
        .server_mask (server_mask_reg),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    vpnfd_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop),
        .expire_seconds (expire_reg),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_res        (res)
    );

    assign action       = res.action;
    assign reason       = res.reason;
    assign block_source = res.block_source;
    assign target_peer  = res.target_peer;
    assign target_addr  = res.target_addr;

endmodule

`default_nettype wire
